// ===== hw/rtl/stream_find_replace_unit_assert.svh =====
// Assertion macros shared by the find/replace RTL.
// No dependencies; define ASSERT_OFF to compile them out.
`ifndef STREAM_FIND_REPLACE_UNIT_ASSERT_SVH
`define STREAM_FIND_REPLACE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define SFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `SFR_ASSERT(lbl, clk, rst_n, !(cond), msg)

`else

`define SFR_ASSERT(lbl, clk, rst_n, prop, msg)

`define SFR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hw/rtl/sfr_pkg.sv =====
// Types and constants of the stream find/replace unit.
// No dependencies; used by sfr_cell and stream_find_replace_unit.
package sfr_pkg;

  localparam int RepMaxBytes = 8;
  localparam int RepLenW     = 4;
  localparam int RepIdxW     = 3;

  // configuration register indices
  localparam logic [1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  typedef logic [7:0] octet_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cand;   // incoming byte lands here for the compare
    logic load;   // store the incoming byte
    logic shift;  // take the neighbour's byte
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sfr_cell.sv =====
// One window cell: holds a pending byte, compares it against its pattern byte.
// Depends on sfr_pkg.
module sfr_cell
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  octet_t     char_in,
  input  octet_t     right_byte,
  input  octet_t     pat_byte,
  output octet_t     cell_byte,
  output logic       eq
);

  octet_t byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (ctrl.load) begin
      byte_r <= char_in;
    end else if (ctrl.shift) begin
      byte_r <= right_byte;
    end
  end

  assign cell_byte = byte_r;
  assign eq        = ((ctrl.cand ? char_in : byte_r) == pat_byte);

endmodule

// ===== hw/rtl/stream_find_replace_unit.sv =====
// Streaming find/replace: every leftmost, non-overlapping occurrence of the pattern in the
// byte stream is replaced. The input stalls while the output register holds an untaken word,
// while a replacement of more than one byte is sent, and while an end-of-string flush sends
// the bytes still pending; the single output register sends one word per cycle while the
// receiver is ready, and a stalled receiver adds its own wait. There is no clearing pass
// after reset.
// Depends on sfr_pkg, sfr_cell and the assertion header.
`include "stream_find_replace_unit_assert.svh"

module stream_find_replace_unit
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  // source stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in
  input  logic        in_tuser,   // has_char
  input  logic        in_tlast,   // end_of_string
  // rewritten stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // char_out
  output logic        out_tuser,  // char_valid
  output logic        out_tlast   // last_out
);

  localparam int FW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int NC = MAX_PATTERN_BYTES;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_REPL  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [63:0]        pat_r, repl_r;
  logic [3:0]         plen_r;
  logic [RepLenW-1:0] rlen_r;

  logic [1:0]         state_r, state_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [RepIdxW-1:0] ridx_r, ridx_nxt;
  logic               eos_r, eos_nxt;

  logic               otv_r, otv_nxt;
  octet_t             odata_r, odata_nxt;
  logic               ouser_r, ouser_nxt;
  logic               olast_r, olast_nxt;

  logic [FW-1:0]      plen_eff, newfill;
  logic [RepLenW-1:0] rlen_eff;
  logic               ofree, acc, full, match;
  logic               acc_load, shift_acc, flush_step;
  logic               emit, e_valid, e_last;
  octet_t             e_byte, head, repl_byte;

  cell_ctrl_t         ctrl [NC];
  octet_t             cbyte [NC];
  logic [NC-1:0]      eq, mask;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= '0;
      repl_r <= '0;
      rlen_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:      pat_r  <= cfg_wdata;
        CFG_PATTERN_LENGTH:     plen_r <= cfg_wdata[3:0];
        CFG_REPLACEMENT_BYTES:  repl_r <= cfg_wdata;
        CFG_REPLACEMENT_LENGTH: rlen_r <= cfg_wdata[RepLenW-1:0];
        default: ;
      endcase
    end
  end

  assign plen_eff = (plen_r > 4'(NC)) ? FW'(NC) : FW'(plen_r);
  assign rlen_eff = (rlen_r > RepLenW'(RepMaxBytes)) ? RepLenW'(RepMaxBytes) : rlen_r;

  // window cells, oldest byte in cell 0
  for (genvar i = 0; i < NC; i++) begin : g_cell
    assign ctrl[i].cand  = in_tuser && (fill_r == FW'(i));
    assign ctrl[i].load  = acc_load &&
                           (shift_acc ? (fill_r == FW'(i + 1)) : (fill_r == FW'(i)));
    assign ctrl[i].shift = shift_acc || flush_step;
    assign mask[i]       = (FW'(i) < plen_eff);

    sfr_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl[i]),
      .char_in    (in_tdata),
      .right_byte ((i == NC - 1) ? 8'h00 : cbyte[(i + 1) % NC]),
      .pat_byte   (pat_r[8*i +: 8]),
      .cell_byte  (cbyte[i]),
      .eq         (eq[i])
    );
  end

  assign match     = &(eq | ~mask);
  assign ofree     = !otv_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && ofree;
  assign acc       = in_tvalid && in_tready;
  assign newfill   = fill_r + FW'(1);
  assign full      = (newfill == plen_eff);
  assign head      = (fill_r == '0) ? in_tdata : cbyte[0];
  assign repl_byte = repl_r[{ridx_r, 3'b000} +: 8];

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    ridx_nxt   = ridx_r;
    eos_nxt    = eos_r;
    acc_load   = 1'b0;
    shift_acc  = 1'b0;
    flush_step = 1'b0;
    emit       = 1'b0;
    e_byte     = '0;
    e_valid    = 1'b0;
    e_last     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          eos_nxt = in_tlast;
          if (in_tuser && plen_eff == '0) begin
            emit    = 1'b1;
            e_byte  = in_tdata;
            e_valid = 1'b1;
            e_last  = in_tlast;
          end else if (in_tuser) begin
            acc_load = 1'b1;
            if (!full) begin
              fill_nxt = newfill;
              if (in_tlast) state_nxt = S_FLUSH;
            end else if (match) begin
              fill_nxt = '0;
              if (rlen_eff != '0) begin
                emit    = 1'b1;
                e_byte  = repl_r[7:0];
                e_valid = 1'b1;
                e_last  = in_tlast && (rlen_eff == RepLenW'(1));
                if (rlen_eff > RepLenW'(1)) begin
                  state_nxt = S_REPL;
                  ridx_nxt  = RepIdxW'(1);
                end
              end else if (in_tlast) begin
                emit   = 1'b1;
                e_last = 1'b1;
              end
            end else begin
              // window full, no match: oldest byte out, window slides
              shift_acc = 1'b1;
              emit      = 1'b1;
              e_byte    = head;
              e_valid   = 1'b1;
              if (in_tlast) begin
                if (fill_r == '0) e_last = 1'b1;
                else state_nxt = S_FLUSH;
              end
            end
          end else if (in_tlast) begin
            if (fill_r != '0) begin
              state_nxt = S_FLUSH;
            end else begin
              emit   = 1'b1;
              e_last = 1'b1;
            end
          end
        end
      end
      S_REPL: begin
        if (ofree) begin
          emit    = 1'b1;
          e_byte  = repl_byte;
          e_valid = 1'b1;
          if ({1'b0, ridx_r} == rlen_eff - RepLenW'(1)) begin
            e_last   = eos_r;
            state_nxt = S_IDLE;
          end else begin
            ridx_nxt = ridx_r + RepIdxW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (ofree) begin
          flush_step = 1'b1;
          emit       = 1'b1;
          e_byte     = cbyte[0];
          e_valid    = 1'b1;
          fill_nxt   = fill_r - FW'(1);
          if (fill_r == FW'(1)) begin
            e_last    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we && cfg_index == CFG_PATTERN_LENGTH) fill_nxt = '0;
  end

  // output register
  always_comb begin
    otv_nxt   = otv_r;
    odata_nxt = odata_r;
    ouser_nxt = ouser_r;
    olast_nxt = olast_r;
    if (emit) begin
      otv_nxt   = 1'b1;
      odata_nxt = e_byte;
      ouser_nxt = e_valid;
      olast_nxt = e_last;
    end else if (out_tready) begin
      otv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ridx_r  <= '0;
      eos_r   <= 1'b0;
      otv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ridx_r  <= ridx_nxt;
      eos_r   <= eos_nxt;
      otv_r   <= otv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = otv_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

  `SFR_ASSERT(a_fill_le_plen, clk, rst_n, fill_r <= plen_eff, "window fill beyond pattern length")
  `SFR_ASSERT_NEVER(a_flush_empty, clk, rst_n, state_r == S_FLUSH && fill_r == '0, "flush with empty window")
  `SFR_ASSERT(a_repl_idx, clk, rst_n, state_r == S_REPL |-> (ridx_r != '0 && {1'b0, ridx_r} < rlen_eff), "replacement index out of range")
  `SFR_ASSERT(a_bare_word, clk, rst_n, out_tvalid && !out_tuser |-> out_tlast && out_tdata == 8'h00, "bare word without last mark")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stream_find_replace_unit: a directed table, then random phases
// of text with varying find/replace settings. Depends on sfr_pkg and the unit's RTL.

module tb_top
  import sfr_pkg::*;
();

  localparam int WINDOW_BYTES  = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int ITEM_TARGET   = 220;

  typedef struct packed {
    octet_t ch;
    logic   valid;
    logic   last;
  } out_word_t;

  // how a source word's results are known: from the predictor, or typed in the table
  typedef enum logic [1:0] {BY_MODEL, NO_WORD, ONE_WORD} row_check_t;

  typedef struct packed {
    logic        is_reg;
    logic [1:0]  idx;
    logic [63:0] val;
    octet_t      ch;
    logic        has;
    logic        eos;
    row_check_t  chk;
    out_word_t   word;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // char_in
  logic        in_tuser = 1'b0; // has_char
  logic        in_tlast = 1'b0; // end_of_string
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // char_out
  logic        out_tuser;       // char_valid
  logic        out_tlast;       // last_out

  // travels with the source word it describes
  row_check_t  row_check = BY_MODEL;
  out_word_t   row_word = '0;

  // mirror of the unit's registers and window
  logic [63:0] pat_bytes = '0;
  logic [3:0]  pat_len = '0;
  logic [63:0] rep_bytes = '0;
  logic [3:0]  rep_len = '0;
  octet_t      win_bytes [WINDOW_BYTES];
  int          win_fill = 0;

  out_word_t   fresh_words[$];
  out_word_t   due_words[$];
  plan_row_t   plan[$];

  int fail_count = 0;
  int items_sent = 0;
  int words_in = 0;
  int words_out = 0;
  int regs_written = 0;
  int phases = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  logic [7:0] stall_pat = 8'b1101_0110;
  bit letters = 1'b1;

  stream_find_replace_unit #(.MAX_PATTERN_BYTES(WINDOW_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void emit(input octet_t b, input logic v);
    out_word_t w;
    w.ch = b;
    w.valid = v;
    w.last = 1'b0;
    fresh_words.push_back(w);
  endfunction

  // rewritten words caused by one source word, left in fresh_words
  function automatic void rewrite_item(input octet_t ch, input logic has, input logic eos);
    int plen, rlen;
    logic hit;
    out_word_t w;
    plen = (pat_len > WINDOW_BYTES) ? WINDOW_BYTES : int'(pat_len);
    rlen = (rep_len > RepMaxBytes) ? RepMaxBytes : int'(rep_len);
    fresh_words.delete();
    if (win_fill > plen) win_fill = 0;
    if (has) begin
      if (plen == 0) begin
        emit(ch, 1'b1);
      end else begin
        if (win_fill < WINDOW_BYTES) begin
          win_bytes[win_fill] = ch;
          win_fill++;
        end
        if (win_fill >= plen) begin
          hit = 1'b1;
          for (int i = 0; i < plen; i++)
            if (win_bytes[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
          if (hit) begin
            for (int i = 0; i < rlen; i++) emit(rep_bytes[8*i +: 8], 1'b1);
            win_fill = 0;
          end else begin
            emit(win_bytes[0], 1'b1);
            for (int i = 1; i < win_fill; i++) win_bytes[i-1] = win_bytes[i];
            win_fill--;
          end
        end
      end
    end
    if (eos) begin
      for (int i = 0; i < win_fill; i++) emit(win_bytes[i], 1'b1);
      win_fill = 0;
      if (fresh_words.size() == 0) emit(8'h00, 1'b0);
      w = fresh_words.pop_back();
      w.last = 1'b1;
      fresh_words.push_back(w);
    end
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [63:0] val);
    case (idx)
      CFG_PATTERN_BYTES: pat_bytes = val;
      CFG_PATTERN_LENGTH: begin
        pat_len = val[3:0];
        win_fill = 0;
      end
      CFG_REPLACEMENT_BYTES: rep_bytes = val;
      CFG_REPLACEMENT_LENGTH: rep_len = val[3:0];
      default: ;
    endcase
  endfunction

  // receiver stalls: always ready, a rotating pattern, or coin flips
  always @(posedge clk) begin
    stall_pat <= {stall_pat[6:0], stall_pat[7]};
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= stall_pat[0];
      default: out_tready <= ($urandom_range(0, 2) != 0);
    endcase
  end

  always @(posedge clk) begin : track
    out_word_t got, want;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        words_in++;
        rewrite_item(in_tdata, in_tuser, in_tlast);
        if (row_check != BY_MODEL) begin
          fresh_words.delete();
          if (row_check == ONE_WORD) fresh_words.push_back(row_word);
        end
        foreach (fresh_words[k]) due_words.push_back(fresh_words[k]);
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        words_out++;
        got.ch = out_tdata;
        got.valid = out_tuser;
        got.last = out_tlast;
        if (due_words.size() == 0) begin
          $error("word %02h valid %0b last %0b arrived with none expected",
                 got.ch, got.valid, got.last);
          fail_count++;
        end else begin
          want = due_words.pop_front();
          if (got.ch !== want.ch) begin
            $error("char_out: expected %02h, got %02h", want.ch, got.ch);
            fail_count++;
          end
          if (got.valid !== want.valid) begin
            $error("char_valid: expected %0b, got %0b", want.valid, got.valid);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last_out: expected %0b, got %0b", want.last, got.last);
            fail_count++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("stalled: no word moved for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // hold the source until every owed word has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_words.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    regs_written++;
  endtask

  task automatic send_word(input octet_t ch, input logic has, input logic eos,
                           input row_check_t chk, input out_word_t word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tuser <= has;
    in_tlast <= eos;
    row_check <= chk;
    row_word <= word;
    do @(posedge clk); while (!in_tready);
    if (has || eos) items_sent++;
  endtask

  function automatic void reg_row(input logic [1:0] idx, input logic [63:0] val);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endfunction

  function automatic void item_row(input octet_t ch, input logic has, input logic eos,
                                   input row_check_t chk, input out_word_t word);
    plan_row_t r;
    r = '0;
    r.ch = ch;
    r.has = has;
    r.eos = eos;
    r.chk = chk;
    r.word = word;
    plan.push_back(r);
  endfunction

  function automatic octet_t pick_letter();
    return octet_t'(8'h61 + $urandom_range(0, 3));
  endfunction

  task automatic random_settings();
    logic [63:0] pat;
    int r, plen, rlen;
    letters = ($urandom_range(0, 9) < 7);
    if (letters) begin
      for (int i = 0; i < 8; i++) pat[8*i +: 8] = pick_letter();
    end else begin
      pat = {$urandom, $urandom};
    end
    r = $urandom_range(0, 9);
    plen = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : (r == 2) ? 8 : $urandom_range(1, 4);
    r = $urandom_range(0, 9);
    rlen = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
    if ($urandom_range(0, 4) != 0) write_reg(CFG_PATTERN_BYTES, pat);
    if ($urandom_range(0, 4) != 0) write_reg(CFG_PATTERN_LENGTH, 64'(plen));
    if ($urandom_range(0, 4) != 0) write_reg(CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
    if ($urandom_range(0, 4) != 0) write_reg(CFG_REPLACEMENT_LENGTH, 64'(rlen));
  endtask

  task automatic random_chunk();
    int r, plen, cut;
    octet_t ch;
    r = $urandom_range(0, 99);
    plen = (pat_len > WINDOW_BYTES) ? WINDOW_BYTES : int'(pat_len);
    if (r < 6) begin
      send_word(octet_t'($urandom_range(0, 255)), 1'b0, 1'b0, BY_MODEL, '0);
    end else if (r < 12) begin
      send_word(octet_t'($urandom_range(0, 255)), 1'b0, 1'b1, BY_MODEL, '0);
    end else if (r < 20) begin
      send_word(octet_t'($urandom_range(0, 255)), 1'b1, ($urandom_range(0, 7) == 0),
                BY_MODEL, '0);
    end else if (r < 55 && plen > 0) begin
      // the whole pattern, or a prefix of it broken off
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
      for (int i = 0; i < cut; i++)
        send_word(pat_bytes[8*i +: 8], 1'b1, (i == cut - 1) && ($urandom_range(0, 7) == 0),
                  BY_MODEL, '0);
    end else begin
      ch = letters ? pick_letter() : octet_t'($urandom_range(0, 255));
      send_word(ch, 1'b1, ($urandom_range(0, 9) == 0), BY_MODEL, '0);
    end
    if ($urandom_range(0, 39) == 0) drain();
  endtask

  initial begin
    int n;
    foreach (win_bytes[i]) win_bytes[i] = '0;

    // registers at reset: plain pass-through
    item_row(8'h00, 1'b1, 1'b0, ONE_WORD, {8'h00, 1'b1, 1'b0});
    item_row(8'hFF, 1'b1, 1'b1, ONE_WORD, {8'hFF, 1'b1, 1'b1});
    item_row(8'h5A, 1'b0, 1'b1, ONE_WORD, {8'h00, 1'b0, 1'b1});  // bare end
    item_row(8'hA5, 1'b0, 1'b0, NO_WORD, '0);                   // bare idle
    // "ab" -> "XYZ"
    reg_row(CFG_PATTERN_BYTES, 64'h6261);
    reg_row(CFG_PATTERN_LENGTH, 64'd2);
    reg_row(CFG_REPLACEMENT_BYTES, 64'h5A5958);
    reg_row(CFG_REPLACEMENT_LENGTH, 64'd3);
    item_row(8'h78, 1'b1, 1'b0, BY_MODEL, '0);
    item_row(8'h61, 1'b1, 1'b0, BY_MODEL, '0);
    item_row(8'h62, 1'b1, 1'b0, BY_MODEL, '0);
    item_row(8'h61, 1'b1, 1'b0, BY_MODEL, '0);
    item_row(8'h61, 1'b1, 1'b0, BY_MODEL, '0);
    item_row(8'h62, 1'b1, 1'b1, BY_MODEL, '0);
    item_row(8'h71, 1'b1, 1'b1, ONE_WORD, {8'h71, 1'b1, 1'b1});
    // over-long pattern length saturates; empty replacement swallows the match
    reg_row(CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_row(CFG_PATTERN_LENGTH, 64'd15);
    reg_row(CFG_REPLACEMENT_LENGTH, 64'd0);
    for (int i = 0; i < 8; i++) item_row(8'hFF, 1'b1, 1'b0, BY_MODEL, '0);
    item_row(8'h00, 1'b0, 1'b1, ONE_WORD, {8'h00, 1'b0, 1'b1});
    // over-long replacement length saturates to eight bytes
    reg_row(CFG_REPLACEMENT_BYTES, 64'h0123_4567_89AB_CDEF);
    reg_row(CFG_REPLACEMENT_LENGTH, 64'd12);
    reg_row(CFG_PATTERN_BYTES, 64'h00);
    reg_row(CFG_PATTERN_LENGTH, 64'd1);
    item_row(8'h00, 1'b1, 1'b0, BY_MODEL, '0);
    item_row(8'h7F, 1'b1, 1'b1, ONE_WORD, {8'h7F, 1'b1, 1'b1});
    // a pattern length write throws away the pending window
    reg_row(CFG_PATTERN_BYTES, 64'h636261);
    reg_row(CFG_PATTERN_LENGTH, 64'd3);
    item_row(8'h61, 1'b1, 1'b0, NO_WORD, '0);
    item_row(8'h62, 1'b1, 1'b0, NO_WORD, '0);
    reg_row(CFG_PATTERN_LENGTH, 64'd3);
    item_row(8'h00, 1'b0, 1'b1, ONE_WORD, {8'h00, 1'b0, 1'b1});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].ch, plan[i].has, plan[i].eos, plan[i].chk, plan[i].word);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      random_settings();
      stall_mode = $urandom_range(0, 2);
      phases++;
      n = $urandom_range(15, 35);
      for (int k = 0; k < n; k++) random_chunk();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d source words, %0d rewritten words, %0d register writes",
             words_in, words_out, regs_written);
    $display("across %0d random find/replace settings after the directed table", phases);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_cell.sv
hw/rtl/stream_find_replace_unit.sv
bench/tb_top.sv
